/* sv/ssd_pkg.sv */
package ssd_pkg;

	localparam int NUM_SLOTS  = 4;
	localparam int SLOT_W     = 2;
	localparam int DIGIT_W    = 4;
	localparam int COUNT_W    = 8;
	localparam int FRAME_W    = 16;
	localparam int BIT_CNT_W  = 4;
	localparam int APB_ADDR_W = 2;
	localparam int APB_DATA_W = 32;

	localparam logic [APB_ADDR_W-1:0] REG_DIGIT_ENABLE_ADDR = 2'd0;
	localparam logic [NUM_SLOTS-1:0]  DIGIT_ENABLE_RESET    = 4'hF;
	localparam logic [BIT_CNT_W-1:0]  LAST_BIT              = 4'd15;

	// reciprocal of ten as 205 / 2048, exact for counts up to 255
	localparam logic [COUNT_W-1:0] RECIP_TEN   = 8'd205;
	localparam int                 RECIP_SHIFT = 11;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_SCAN  = 2'd1,
		OP_BLANK = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef struct packed {
		logic               load;
		logic [FRAME_W-1:0] word;
	} frame_req_t;

	typedef struct packed {
		logic free;
	} shift_status_t;

	// active-low segment patterns, out-of-range digits light every segment
	function automatic logic [7:0] seg_code(input logic [DIGIT_W-1:0] d);
		logic [7:0] code;
		unique case (d)
			4'd0: code = 8'hC0;
			4'd1: code = 8'hF9;
			4'd2: code = 8'hA4;
			4'd3: code = 8'hB0;
			4'd4: code = 8'h99;
			4'd5: code = 8'h92;
			4'd6: code = 8'h82;
			4'd7: code = 8'hF8;
			4'd8: code = 8'h80;
			4'd9: code = 8'h90;
			default: code = 8'h00;
		endcase
		return code;
	endfunction

	// digit select byte, one-hot in reversed slot order
	function automatic logic [7:0] slot_select(input logic [SLOT_W-1:0] s);
		logic [7:0] sel;
		unique case (s)
			2'd0: sel = 8'h08;
			2'd1: sel = 8'h04;
			2'd2: sel = 8'h02;
			default: sel = 8'h01;
		endcase
		return sel;
	endfunction

endpackage

/* sv/ssd_digit_split.sv */
module ssd_digit_split (
	input  logic [ssd_pkg::COUNT_W-1:0] count,
	output logic [ssd_pkg::DIGIT_W-1:0] tens,
	output logic [ssd_pkg::DIGIT_W-1:0] ones
);
	import ssd_pkg::*;

	localparam int PROD_W = 2 * COUNT_W;
	localparam int QUOT_W = PROD_W - RECIP_SHIFT;

	logic [PROD_W-1:0]  prod;
	logic [QUOT_W-1:0]  quot;
	logic [COUNT_W-1:0] quot_x10;
	logic [COUNT_W-1:0] rem;

	// count / 10 by reciprocal multiply
	assign prod     = PROD_W'(count) * PROD_W'(RECIP_TEN);
	assign quot     = prod[PROD_W-1:RECIP_SHIFT];
	assign quot_x10 = (COUNT_W'(quot) << 3) + (COUNT_W'(quot) << 1);
	assign rem      = count - quot_x10;
	assign ones     = rem[DIGIT_W-1:0];

	// quotient stays below 30, so two compare-subtract steps finish the mod
	always_comb begin
		if (quot >= QUOT_W'(20)) begin
			tens = DIGIT_W'(quot - QUOT_W'(20));
		end else if (quot >= QUOT_W'(10)) begin
			tens = DIGIT_W'(quot - QUOT_W'(10));
		end else begin
			tens = DIGIT_W'(quot);
		end
	end

endmodule

/* sv/ssd_shifter.sv */
module ssd_shifter (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ssd_pkg::frame_req_t   req,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic                  serial_bit,
	output logic                  latch_after,
	output ssd_pkg::shift_status_t status
);
	import ssd_pkg::*;

	logic [FRAME_W-1:0]   word_q;
	logic [BIT_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 last_bit;

	assign last_bit    = (cnt_q == LAST_BIT);
	assign out_valid   = busy_q;
	assign serial_bit  = ~word_q[FRAME_W-1];
	assign latch_after = last_bit;
	assign status.free = !busy_q || (out_ready && last_bit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.load) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q && out_ready) begin
			if (last_bit) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + BIT_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (req.load) begin
			word_q <= req.word;
		end else if (busy_q && out_ready) begin
			word_q <= {word_q[FRAME_W-2:0], 1'b0};
		end
	end

endmodule

/* sv/seven_segment_scan_serializer.sv */
// Four-digit multiplexed seven-segment driver for two chained 8-bit serial
// shift registers. A load transfer splits count_first into slots 0 (tens) and
// 1 (ones) and count_second into slots 2 and 3; it produces no output. A
// scan transfer shows the digit of the current slot (when its digit_enable
// bit is set and the digit is nonzero, or it is a ones digit with a nonzero
// tens digit) and then steps the slot. A blank transfer sends an all-off
// frame. Each frame is 16 output transfers, MSB first and inverted: segment
// byte, then digit select byte; latch_after marks the sixteenth, after which
// the latch should be pulsed. The bit shifter sets the rate: a shown frame
// holds the shifter until its last bit is taken, and the next frame starts
// in the cycle after the latch bit, so frames stream with no gap. Loads and
// hidden scans retire without waiting while a frame is shifting.
// digit_enable sits at APB address 0 and resets to all slots enabled.
module seven_segment_scan_serializer (
	input  logic                            clk,
	input  logic                            arst_n,
	// apb configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ssd_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [ssd_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [ssd_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	// command channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      operation,
	input  logic [ssd_pkg::COUNT_W-1:0]     count_first,
	input  logic [ssd_pkg::COUNT_W-1:0]     count_second,
	// serial bit channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            serial_bit,
	output logic                            latch_after
);
	import ssd_pkg::*;

	// configuration
	logic [NUM_SLOTS-1:0] digit_enable_q;
	logic                 cfg_write;

	// input register
	logic                 in_valid_s1;
	op_t                  op_s1;
	logic [COUNT_W-1:0]   count_first_s1;
	logic [COUNT_W-1:0]   count_second_s1;

	// digit state
	logic [DIGIT_W-1:0]   digit_q [NUM_SLOTS];
	logic [SLOT_W-1:0]    scan_slot_q;

	// stage logic
	logic [DIGIT_W-1:0]   first_tens, first_ones, second_tens, second_ones;
	logic [DIGIT_W-1:0]   cur_digit;
	logic                 slot_allowed;
	logic                 slot_visible;
	logic                 needs_frame;
	logic                 s1_fire;
	frame_req_t           frame_req;
	shift_status_t        shift_status;

	// apb: zero wait states, one register
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready
		&& (paddr == REG_DIGIT_ENABLE_ADDR);
	assign prdata    = (paddr == REG_DIGIT_ENABLE_ADDR)
		? APB_DATA_W'(digit_enable_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_enable_q <= DIGIT_ENABLE_RESET;
		end else if (cfg_write) begin
			digit_enable_q <= pwdata[NUM_SLOTS-1:0];
		end
	end

	// the input register frees up whenever its item retires
	assign in_ready = !in_valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1           <= op_t'(operation);
			count_first_s1  <= count_first;
			count_second_s1 <= count_second;
		end
	end

	// tens and ones of both counts
	ssd_digit_split u_split_first (
		.count (count_first_s1),
		.tens  (first_tens),
		.ones  (first_ones)
	);

	ssd_digit_split u_split_second (
		.count (count_second_s1),
		.tens  (second_tens),
		.ones  (second_ones)
	);

	// visibility: nonzero digit, or a ones digit behind a nonzero tens digit
	assign cur_digit    = digit_q[scan_slot_q];
	assign slot_allowed = digit_enable_q[scan_slot_q];
	assign slot_visible = (cur_digit != '0)
		|| ((scan_slot_q == SLOT_W'(1)) && (digit_q[0] != '0))
		|| ((scan_slot_q == SLOT_W'(3)) && (digit_q[2] != '0));

	always_comb begin
		needs_frame = 1'b0;
		case (op_s1)
			OP_SCAN:  needs_frame = slot_allowed && slot_visible;
			OP_BLANK: needs_frame = 1'b1;
			default:  needs_frame = 1'b0;
		endcase
	end

	// a frame-producing item waits for the shifter, everything else retires now
	assign s1_fire = in_valid_s1 && (!needs_frame || shift_status.free);

	assign frame_req.load = s1_fire && needs_frame;
	assign frame_req.word = (op_s1 == OP_BLANK) ? '0
		: {seg_code(cur_digit), slot_select(scan_slot_q)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_slot_q <= '0;
			digit_q[0]  <= 4'd1;
			digit_q[1]  <= 4'd2;
			digit_q[2]  <= 4'd3;
			digit_q[3]  <= 4'd4;
		end else if (s1_fire) begin
			case (op_s1)
				OP_LOAD: begin
					digit_q[0] <= first_tens;
					digit_q[1] <= first_ones;
					digit_q[2] <= second_tens;
					digit_q[3] <= second_ones;
				end
				OP_SCAN: begin
					scan_slot_q <= scan_slot_q + SLOT_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	ssd_shifter u_shifter (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (frame_req),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.serial_bit  (serial_bit),
		.latch_after (latch_after),
		.status      (shift_status)
	);

	// slot only moves on a retiring scan
	assert property (@(posedge clk) disable iff (!arst_n)
		!(s1_fire && (op_s1 == OP_SCAN)) |=> $stable(scan_slot_q))
		else $error("scan slot moved without a scan");

	// a new frame never cuts into one still shifting
	assert property (@(posedge clk) disable iff (!arst_n)
		frame_req.load |-> (!out_valid || (out_ready && latch_after)))
		else $error("frame loaded over a busy shifter");

	// stored digits are always decimal
	assert property (@(posedge clk) disable iff (!arst_n)
		(digit_q[0] <= 4'd9) && (digit_q[1] <= 4'd9)
		&& (digit_q[2] <= 4'd9) && (digit_q[3] <= 4'd9))
		else $error("digit out of decimal range");

	// a held item with no frame to send retires at once
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid_s1 && !needs_frame) |-> in_ready)
		else $error("frameless item stalled");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
	import ssd_pkg::*;

	// generous cap on the whole run, far above the slowest legal run
	localparam int CYCLE_LIMIT = 400000;
	// quiet cycles after the last frame bit, covers loads and hidden scans in flight
	localparam int SETTLE_CYCLES = 12;
	// random commands per configuration phase
	localparam int PHASE_BUDGET = 70;

	typedef struct packed {
		op_t                op;
		logic [COUNT_W-1:0] first;
		logic [COUNT_W-1:0] second;
	} cmd_t;

	typedef struct packed {
		logic data_bit;
		logic latch;
	} frame_bit_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// apb side, idle until a register transfer
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	// command channel
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         operation = OP_NOP;
	logic [COUNT_W-1:0] count_first = '0;
	logic [COUNT_W-1:0] count_second = '0;

	// serial bit channel
	logic out_valid;
	logic out_ready = 1'b0;
	logic serial_bit;
	logic latch_after;

	seven_segment_scan_serializer uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.count_first  (count_first),
		.count_second (count_second),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.serial_bit   (serial_bit),
		.latch_after  (latch_after)
	);

	always #5 clk = ~clk;

	// commands waiting for the driver, and frame bits waiting for the monitor
	cmd_t       pending_cmds[$];
	frame_bit_t expected_bits[$];
	cmd_t       in_flight;

	// shadow of the display state
	logic [DIGIT_W-1:0]   shown_digits[NUM_SLOTS];
	logic [SLOT_W-1:0]    next_slot;
	logic [NUM_SLOTS-1:0] enable_mask;

	// idle percentages of the two sides, changed between phases
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;

	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	int unsigned bits_checked = 0;
	int unsigned frames_expected = 0;
	int unsigned loads_seen = 0;
	int unsigned scans_seen = 0;
	int unsigned blanks_seen = 0;
	int unsigned settings_used = 0;

	// active-low segment pattern of one digit, every segment lit above nine
	function automatic logic [7:0] glyph_bits(input logic [DIGIT_W-1:0] d);
		case (d)
			4'd0: return 8'hC0;
			4'd1: return 8'hF9;
			4'd2: return 8'hA4;
			4'd3: return 8'hB0;
			4'd4: return 8'h99;
			4'd5: return 8'h92;
			4'd6: return 8'h82;
			4'd7: return 8'hF8;
			4'd8: return 8'h80;
			4'd9: return 8'h90;
			default: return 8'h00;
		endcase
	endfunction

	// sixteen inverted bits msb first, latch flagged on the last one
	function automatic void queue_frame(input logic [7:0] seg, input logic [7:0] sel);
		logic [FRAME_W-1:0] word;
		frame_bit_t         fb;
		word = {seg, sel};
		for (int k = 0; k < FRAME_W; k++) begin
			fb.data_bit = ~word[FRAME_W-1-k];
			fb.latch = (k == FRAME_W - 1);
			expected_bits.push_back(fb);
		end
		frames_expected++;
	endfunction

	// advance the shadow state by one accepted command
	function automatic void compute_frame_bits(input cmd_t c);
		logic [SLOT_W-1:0]  s;
		logic [DIGIT_W-1:0] d;
		logic               lit;
		case (c.op)
			OP_LOAD: begin
				shown_digits[0] = DIGIT_W'((int'(c.first) / 10) % 10);
				shown_digits[1] = DIGIT_W'(int'(c.first) % 10);
				shown_digits[2] = DIGIT_W'((int'(c.second) / 10) % 10);
				shown_digits[3] = DIGIT_W'(int'(c.second) % 10);
				loads_seen++;
			end
			OP_SCAN: begin
				s = next_slot;
				d = shown_digits[s];
				// a ones digit of zero still lights when its tens digit is nonzero
				lit = (d != 0) || (s == 2'd1 && shown_digits[0] != 0) ||
					(s == 2'd3 && shown_digits[2] != 0);
				if (enable_mask[s] && lit) begin
					queue_frame(glyph_bits(d), 8'h08 >> s);
				end
				next_slot = s + 1'b1;
				scans_seen++;
			end
			OP_BLANK: begin
				queue_frame(8'h00, 8'h00);
				blanks_seen++;
			end
			default: begin
			end
		endcase
	endfunction

	// driver: holds the command until accepted, then maybe idles, then offers the next
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				compute_frame_bits(in_flight);
			end
			if (!in_valid || in_ready) begin
				if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					in_flight = pending_cmds.pop_front();
					in_valid <= 1'b1;
					operation <= in_flight.op;
					count_first <= in_flight.first;
					count_second <= in_flight.second;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: every serial transfer is matched against the oldest expected bit
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_bits.size() == 0) begin
					$display("%0t: unexpected transfer serial_bit=%0b latch_after=%0b",
						$time, serial_bit, latch_after);
					error_count++;
				end else begin
					if (serial_bit !== expected_bits[0].data_bit) begin
						$display("%0t: serial_bit mismatch, expected %0b got %0b",
							$time, expected_bits[0].data_bit, serial_bit);
						error_count++;
					end
					if (latch_after !== expected_bits[0].latch) begin
						$display("%0t: latch_after mismatch, expected %0b got %0b",
							$time, expected_bits[0].latch, latch_after);
						error_count++;
					end
					void'(expected_bits.pop_front());
					bits_checked++;
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d commands and %0d bits outstanding",
				$time, pending_cmds.size(), expected_bits.size());
			$display("FAIL seven_segment_scan_serializer");
			$finish;
		end
	end

	// digit_enable write, then read back; the shadow mask follows at the write edge
	task automatic program_enable(input logic [NUM_SLOTS-1:0] mask);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_DIGIT_ENABLE_ADDR;
		pwdata <= APB_DATA_W'(mask);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		enable_mask = mask;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[NUM_SLOTS-1:0] !== mask) begin
			$display("%0t: digit_enable readback mismatch, expected %h got %h",
				$time, mask, prdata[NUM_SLOTS-1:0]);
			error_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		settings_used++;
	endtask

	task automatic push_cmd(input op_t op, input int a, input int b);
		cmd_t c;
		c.op = op;
		c.first = COUNT_W'(a);
		c.second = COUNT_W'(b);
		pending_cmds.push_back(c);
	endtask

	// counts spread over one digit, two digits, three digits, round tens, the extremes and the full range
	function automatic int pick_count();
		case ($urandom_range(5))
			0: return $urandom_range(9);
			1: return $urandom_range(99, 10);
			2: return $urandom_range(255, 100);
			3: return 10 * $urandom_range(25);
			4: return $urandom_range(1) ? 255 : 0;
			default: return $urandom_range(255);
		endcase
	endfunction

	// mostly a load followed by a run of scans and some blanks, plus loose scans, blanks, loads and noise
	task automatic queue_random_phase(input int budget);
		int counted;
		int pick;
		int run_len;
		counted = 0;
		while (counted < budget) begin
			pick = $urandom_range(99);
			if (pick < 65) begin
				push_cmd(OP_LOAD, pick_count(), pick_count());
				run_len = $urandom_range(9, 3);
				for (int i = 0; i < run_len; i++) begin
					if ($urandom_range(99) < 12) begin
						push_cmd(OP_BLANK, pick_count(), pick_count());
					end else begin
						push_cmd(OP_SCAN, pick_count(), pick_count());
					end
				end
				counted += run_len + 1;
			end else if (pick < 80) begin
				push_cmd(OP_SCAN, pick_count(), pick_count());
				counted++;
			end else if (pick < 90) begin
				push_cmd(OP_BLANK, pick_count(), pick_count());
				counted++;
			end else if (pick < 95) begin
				// unused opcode, the block should swallow it silently
				push_cmd(OP_NOP, pick_count(), pick_count());
			end else begin
				push_cmd(OP_LOAD, pick_count(), pick_count());
				counted++;
			end
		end
	endtask

	// wait for every command to be taken and every frame bit to arrive, then settle
	task automatic drain();
		@(negedge clk);
		while (pending_cmds.size() != 0 || in_valid || expected_bits.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_idling(input int phase);
		if (phase < 2) begin
			send_idle_pct = 9;
			recv_idle_pct = 80;
		end else if (phase < 4) begin
			send_idle_pct = 80;
			recv_idle_pct = 9;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
	endtask

	logic [NUM_SLOTS-1:0] phase_masks[6];

	initial begin
		// shadow state out of reset
		enable_mask = DIGIT_ENABLE_RESET;
		next_slot = '0;
		shown_digits[0] = 4'd1;
		shown_digits[1] = 4'd2;
		shown_digits[2] = 4'd3;
		shown_digits[3] = 4'd4;

		phase_masks[0] = 4'hF;
		phase_masks[1] = 4'h0;
		phase_masks[2] = 4'h5;
		phase_masks[3] = 4'hA;
		phase_masks[4] = NUM_SLOTS'($urandom_range(15));
		phase_masks[5] = 4'hF;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		set_idling(0);

		// directed: reset digits 1 2 3 4 on all four slots
		repeat (4) push_cmd(OP_SCAN, 0, 0);
		push_cmd(OP_BLANK, 255, 255);
		push_cmd(OP_NOP, 255, 255);
		// all zeros, every slot stays dark
		push_cmd(OP_LOAD, 0, 0);
		repeat (4) push_cmd(OP_SCAN, 255, 0);
		// largest counts, hundreds dropped
		push_cmd(OP_LOAD, 255, 255);
		repeat (4) push_cmd(OP_SCAN, 0, 255);
		// leading zero hidden, trailing zero shown behind a nonzero tens digit
		push_cmd(OP_LOAD, 7, 90);
		repeat (4) push_cmd(OP_SCAN, 0, 0);
		// ones zero after tens one, and a count of one hundred showing nothing
		push_cmd(OP_LOAD, 10, 100);
		repeat (4) push_cmd(OP_SCAN, 0, 0);
		drain();

		// random phases, one digit_enable setting each, idling pattern shifts across them
		for (int p = 0; p < 6; p++) begin
			set_idling(p);
			program_enable(phase_masks[p]);
			queue_random_phase(PHASE_BUDGET);
			drain();
		end

		$display("run covered %0d loads, %0d scans, %0d blanks over %0d digit_enable settings",
			loads_seen, scans_seen, blanks_seen, settings_used);
		$display("checked %0d serial transfers in %0d frames", bits_checked, frames_expected);
		if (error_count == 0) begin
			$display("PASS seven_segment_scan_serializer");
		end else begin
			$display("FAIL seven_segment_scan_serializer");
		end
		$finish;
	end

endmodule
